// File: sv/dcrc_pkg.sv
package dcrc_pkg;

  // file type code that gets the final checksum compare
  localparam logic [7:0] FIRMWARE_TYPE = 8'h00;

  // type code held after reset
  localparam logic [7:0] TYPE_RESET = 8'hFF;

  // crc-16 polynomial, msb first
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_MODE_ERR     = 2'd1;
  localparam logic [1:0] ST_UNKNOWN_TYPE = 2'd2;
  localparam logic [1:0] ST_CHECKSUM_ERR = 2'd3;

  // command codes from the front
  localparam logic [1:0] OP_DENIED = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  typedef struct packed {
    logic        mode;
    logic        logged_in;
    logic [7:0]  file_type;
    logic [15:0] expected_crc;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] crc_now;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        is_fw;
    logic [15:0] expected_crc;
    logic [7:0]  data_byte;
    logic        last_byte;
  } cmd_t;

  typedef struct packed {
    logic [15:0] crc_running;
    logic        type_fw;
  } back_state_t;

  // fold one byte into the crc, one bit per step
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/dcrc_front.sv
module dcrc_front (
  input  dcrc_pkg::in_item_t item,
  output dcrc_pkg::cmd_t     cmd
);

  // classify the incoming transaction into a command for the back end
  always_comb begin
    cmd.expected_crc = item.expected_crc;
    cmd.data_byte    = item.data_byte;
    cmd.last_byte    = item.last_byte;
    cmd.is_fw        = (item.file_type == dcrc_pkg::FIRMWARE_TYPE);
    if (item.mode == dcrc_pkg::MODE_DATA) begin
      cmd.op = dcrc_pkg::OP_DATA;
    end else if (item.logged_in) begin
      cmd.op = dcrc_pkg::OP_START;
    end else begin
      cmd.op = dcrc_pkg::OP_DENIED;
    end
  end

endmodule

// File: sv/dcrc_queue.sv
module dcrc_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dcrc_pkg::cmd_t                push_cmd,
  input  logic                          pop,
  output logic                          full,
  output logic                          not_empty,
  output dcrc_pkg::cmd_t                head,
  output logic [dcrc_pkg::QCNT_W-1:0]   count
);

  dcrc_pkg::cmd_t                entries [dcrc_pkg::QDEPTH];
  logic [dcrc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [dcrc_pkg::QPTR_W-1:0]   rd_ptr;

  localparam logic [dcrc_pkg::QPTR_W-1:0] PTR_LAST = dcrc_pkg::QPTR_W'(dcrc_pkg::QDEPTH - 1);
  localparam logic [dcrc_pkg::QCNT_W-1:0] CNT_FULL = dcrc_pkg::QCNT_W'(dcrc_pkg::QDEPTH);

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: sv/dcrc_back.sv
module dcrc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  dcrc_pkg::cmd_t         cmd,
  output logic                   cmd_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dcrc_pkg::out_item_t    out_data,
  output dcrc_pkg::back_state_t  state
);

  logic [15:0]  crc_running;
  logic [15:0]  crc_target;
  logic         type_fw;
  logic [15:0]  crc_folded;
  logic [15:0]  crc_running_next;
  logic [15:0]  crc_target_next;
  logic         type_fw_next;
  logic [1:0]   status_next;

  assign state.crc_running = crc_running;
  assign state.type_fw     = type_fw;

  // take a command whenever the output register is free or draining
  assign cmd_take = cmd_valid && (!out_valid || !out_stall);

  assign crc_folded = dcrc_pkg::crc_fold(crc_running, cmd.data_byte);

  // execute one command
  always_comb begin
    crc_running_next = crc_running;
    crc_target_next  = crc_target;
    type_fw_next     = type_fw;
    status_next      = dcrc_pkg::ST_OK;
    case (cmd.op)
      dcrc_pkg::OP_DENIED: begin
        status_next = dcrc_pkg::ST_MODE_ERR;
      end
      dcrc_pkg::OP_START: begin
        crc_running_next = '0;
        crc_target_next  = cmd.expected_crc;
        type_fw_next     = cmd.is_fw;
        status_next      = cmd.is_fw ? dcrc_pkg::ST_OK : dcrc_pkg::ST_UNKNOWN_TYPE;
      end
      dcrc_pkg::OP_DATA: begin
        crc_running_next = crc_folded;
        if (cmd.last_byte && type_fw && (crc_folded != crc_target)) begin
          status_next = dcrc_pkg::ST_CHECKSUM_ERR;
        end
      end
      default: begin
        status_next = dcrc_pkg::ST_OK;
      end
    endcase
  end

  // download state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running <= '0;
      crc_target  <= '0;
      type_fw     <= (dcrc_pkg::TYPE_RESET == dcrc_pkg::FIRMWARE_TYPE);
    end else if (cmd_take) begin
      crc_running <= crc_running_next;
      crc_target  <= crc_target_next;
      type_fw     <= type_fw_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_data.status  <= status_next;
      out_data.crc_now <= crc_running_next;
    end
  end

endmodule

// File: sv/download_crc16_verifier_unit.sv
// Download CRC-16 verifier (poly 0x1021, init 0, msb first). Each input
// transaction gives exactly one result transaction, in order. Sustained rate
// is one transaction per clock while out_stall is low; the byte fold is a
// combinational unrolled 8-bit CRC update. An accepted transaction enters a
// two-entry command queue and moves from there into the output register when
// that register is free or draining. in_stall rises only when the queue holds
// two commands behind a stalled output register.
module download_crc16_verifier_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dcrc_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dcrc_pkg::out_item_t   out_data
);

  dcrc_pkg::cmd_t                front_cmd;
  dcrc_pkg::cmd_t                q_head;
  dcrc_pkg::back_state_t         back_state;
  logic                          q_full;
  logic                          q_not_empty;
  logic                          q_pop;
  logic [dcrc_pkg::QCNT_W-1:0]   q_count;

  assign in_stall = q_full;

  // classify
  dcrc_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  // command queue
  dcrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  // execute and register the result
  dcrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_take  (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .state     (back_state)
  );

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= dcrc_pkg::QCNT_W'(dcrc_pkg::QDEPTH))
    else $error("command queue overfilled");

  // the shown result carries the crc that the back end now holds
  a_crc_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.crc_now == back_state.crc_running)
    else $error("result crc differs from running crc");

  // checksum errors only for a firmware download
  a_chk_fw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == dcrc_pkg::ST_CHECKSUM_ERR |-> back_state.type_fw)
    else $error("checksum error outside a firmware download");

  // a full queue with a free output must drain next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    q_full && !out_stall |=> !q_full)
    else $error("queue did not drain");
`endif

endmodule
